### src/fla_pkg.sv
package fla_pkg;

  // Field widths of the stream and configuration payloads
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 18;
  localparam int COUNT_W  = 9;
  localparam int POOL_W   = 9;
  localparam int REQ_W    = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // Operation codes carried on the input tuser
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes carried on the output tuser
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_UNITS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_REQUEST = 1'd1;

  // Register reset values
  localparam logic [POOL_W-1:0] POOL_UNITS_RST   = 9'd256;
  localparam logic [REQ_W-1:0]  UNIT_REQUEST_RST = 11'd8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the input beat
    logic exec;     // apply the operation and load the result register
  } cmd_t;

endpackage

### src/fixed_unit_free_list_allocator_unit.sv
// Free-list allocator for one pool of equal-size units.
// Input stream: s_tuser selects the operation (allocate or free), s_tdata
// carries the unit index to free. Output stream: m_tuser carries the status,
// m_tdata the granted index, its byte offset and the free count after the
// operation. Configuration: cfg_we writes pool_units (index 0) or
// unit_request (index 1); the user must do so only while no operation is in
// flight; the block itself does not enforce it. Timing: an input beat is
// taken in the idle state and executed in the exec state, which loads the
// result register; no new beat is taken until the last has executed, as
// the link of the list head comes from a synchronous link memory read
// that must settle after each pop or push before the next pop.
// The result register lets the next input beat be taken while a result waits;
// when the receiver stalls, the pending operation holds until the result
// register drains, and s_tready stays low meanwhile.
// Reset (synchronous, rst high) empties the free list, restarts fresh units
// at index 0, and loads pool_units = 256 and unit_request = 8. The link
// memory is not cleared; only entries already written are ever used.
module fixed_unit_free_list_allocator_unit #(
  parameter int NUM_UNITS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fla_pkg::IN_TDATA_W-1:0] s_tdata,   // [7:0] unit_index
  input  logic                           s_tuser,   // [0] op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] granted_index, [25:8] byte_offset, [34:26] free_count, [39:35] zero
  output logic [fla_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [fla_pkg::STATUS_W-1:0]    m_tuser,  // [1:0] status
  input  logic                            cfg_we,
  input  logic [fla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fla_pkg::CFG_DATA_W-1:0]  cfg_data
);

  fla_pkg::cmd_t cmd;

  logic [fla_pkg::IDX_W-1:0]    granted_index;
  logic [fla_pkg::OFFSET_W-1:0] byte_offset;
  logic [fla_pkg::COUNT_W-1:0]  free_count;

  // Sequence capture and execute, and own the output valid
  fla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Hold list state, link memory, registers and the result payload
  fla_datapath #(
    .NUM_UNITS (NUM_UNITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_op         (s_tuser),
    .in_index      (s_tdata[fla_pkg::IDX_W-1:0]),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (m_tuser),
    .granted_index (granted_index),
    .byte_offset   (byte_offset),
    .free_count    (free_count)
  );

  // Pack the result fields from the lowest bit up, zero fill to whole bytes
  assign m_tdata = {5'd0, free_count, byte_offset, granted_index};

endmodule

### src/fla_ctrl.sv
module fla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output fla_pkg::cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  always_comb begin
    s_tready    = (state == ST_IDLE);
    cmd.capture = s_tvalid && (state == ST_IDLE);
    // Execute only when the result register is empty or drains this cycle
    cmd.exec    = (state == ST_EXEC) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.capture) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd.exec) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### src/fla_datapath.sv
module fla_datapath #(
  parameter int NUM_UNITS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fla_pkg::cmd_t                     cmd,
  input  logic                              in_op,
  input  logic [fla_pkg::IDX_W-1:0]         in_index,
  input  logic                              cfg_we,
  input  logic [fla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fla_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [fla_pkg::STATUS_W-1:0]      status,
  output logic [fla_pkg::IDX_W-1:0]         granted_index,
  output logic [fla_pkg::OFFSET_W-1:0]      byte_offset,
  output logic [fla_pkg::COUNT_W-1:0]       free_count
);

  localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  // Largest pool the built memory can serve, clamped to the register range
  localparam logic [fla_pkg::POOL_W-1:0] CAP =
    (NUM_UNITS > 511) ? 9'd511 : 9'(NUM_UNITS);

  logic [fla_pkg::IDX_W-1:0] link_mem [NUM_UNITS];
  logic [fla_pkg::IDX_W-1:0] link_rd;

  logic [fla_pkg::POOL_W-1:0]  pool_units;
  logic [fla_pkg::REQ_W-1:0]   unit_request;
  logic [fla_pkg::IDX_W-1:0]   list_head, list_head_next;
  logic [fla_pkg::COUNT_W-1:0] listed_count, listed_count_next;
  logic [fla_pkg::POOL_W-1:0]  fresh_next, fresh_next_next;
  logic                        op_q;
  logic [fla_pkg::IDX_W-1:0]   idx_q;

  logic [fla_pkg::POOL_W-1:0]  eff_pool;
  logic [fla_pkg::POOL_W-1:0]  fresh_now, fresh_after;
  logic [fla_pkg::COUNT_W-1:0] count_now, count_after;
  // One bit beyond the request: the largest requests round up to 2048
  logic [fla_pkg::REQ_W:0]     rounded;
  logic [fla_pkg::POOL_W-1:0]  granted;
  logic [fla_pkg::STATUS_W-1:0] status_c;
  logic                        push;
  logic [fla_pkg::POOL_W+fla_pkg::REQ_W:0] product;

  always_comb begin
    eff_pool  = (pool_units < CAP) ? pool_units : CAP;
    fresh_now = (eff_pool > fresh_next) ? eff_pool - fresh_next : '0;
    count_now = listed_count + fresh_now;

    // Round the request: below 2 to 2, up to 4 to 4, else up to a multiple of 8
    if (unit_request > 11'd4) begin
      rounded = ({1'b0, unit_request} + 12'd7) & ~12'd7;
    end else if (unit_request < 11'd2) begin
      rounded = 12'd2;
    end else begin
      rounded = 12'd4;
    end

    list_head_next    = list_head;
    listed_count_next = listed_count;
    fresh_next_next   = fresh_next;
    granted           = '0;
    status_c          = fla_pkg::STATUS_OK;
    push              = 1'b0;

    if (op_q == fla_pkg::OP_ALLOC) begin
      if (listed_count != '0) begin
        granted           = {1'b0, list_head};
        list_head_next    = link_rd;
        listed_count_next = listed_count - 9'd1;
      end else if (fresh_next < eff_pool) begin
        granted         = fresh_next;
        fresh_next_next = fresh_next + 9'd1;
      end else begin
        status_c = fla_pkg::STATUS_EXHAUSTED;
      end
    end else begin
      if (({1'b0, idx_q} >= fresh_next) || ({1'b0, idx_q} >= CAP) ||
          (count_now >= eff_pool)) begin
        status_c = fla_pkg::STATUS_REJECTED;
      end else begin
        push              = 1'b1;
        list_head_next    = idx_q;
        listed_count_next = listed_count + 9'd1;
      end
    end

    fresh_after = (eff_pool > fresh_next_next) ? eff_pool - fresh_next_next : '0;
    count_after = listed_count_next + fresh_after;
    product     = granted * rounded;
  end

  // Link memory: one write port, one registered read of the current head
  always_ff @(posedge clk) begin
    if (cmd.exec && push) begin
      link_mem[AW'(idx_q)] <= list_head;
    end
    link_rd <= link_mem[AW'(list_head)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_units   <= fla_pkg::POOL_UNITS_RST;
      unit_request <= fla_pkg::UNIT_REQUEST_RST;
      list_head    <= '0;
      listed_count <= '0;
      fresh_next   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fla_pkg::REG_POOL_UNITS:   pool_units   <= cfg_data[fla_pkg::POOL_W-1:0];
          fla_pkg::REG_UNIT_REQUEST: unit_request <= cfg_data[fla_pkg::REQ_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        list_head    <= list_head_next;
        listed_count <= listed_count_next;
        fresh_next   <= fresh_next_next;
      end
    end
  end

  // Input latch and result register carry payload only
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= in_op;
      idx_q <= in_index;
    end
    if (cmd.exec) begin
      status        <= status_c;
      granted_index <= granted[fla_pkg::IDX_W-1:0];
      byte_offset   <= product[fla_pkg::OFFSET_W-1:0];
      free_count    <= count_after;
    end
  end

endmodule

### src/fla_checker.sv
module fla_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fla_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [fla_pkg::STATUS_W-1:0]    m_tuser
);

  // Reset drops any pending result
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // An accepted beat is executed before the next one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an operation is in flight");

  // Failed operations grant nothing
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != fla_pkg::STATUS_OK |-> m_tdata[25:0] == 26'd0)
    else $error("grant reported on a failed operation");

  // Status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == fla_pkg::STATUS_OK || m_tuser == fla_pkg::STATUS_EXHAUSTED ||
                 m_tuser == fla_pkg::STATUS_REJECTED)
    else $error("undefined status code");

endmodule

bind fixed_unit_free_list_allocator_unit fla_checker u_fla_checker (.*);

### tb/sv/fixed_unit_free_list_allocator_checker.sv
module fixed_unit_free_list_allocator_checker
  import fla_pkg::*;
#(
  parameter int NUM_UNITS = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic [STATUS_W-1:0]    m_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     pending,
  output int                     grants_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    index;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
  } grant_t;

  // Shadow allocator state
  logic [IDX_W-1:0]   links [NUM_UNITS];
  logic [IDX_W-1:0]   list_top;
  logic [COUNT_W-1:0] listed_units;
  logic [COUNT_W-1:0] fresh_next;
  logic [POOL_W-1:0]  pool_units_q;
  logic [REQ_W-1:0]   unit_request_q;

  grant_t expected_grants [$];
  int     fail_count    = 0;
  int     checked_count = 0;

  function automatic int pool_limit();
    return (pool_units_q < NUM_UNITS) ? int'(pool_units_q) : NUM_UNITS;
  endfunction

  function automatic int rounded_bytes();
    int r;
    r = int'(unit_request_q);
    if (r > 4) return (r + 7) & ~7;
    if (r < 2) return 2;
    return 4;
  endfunction

  function automatic int units_free();
    int lim;
    int fresh_left;
    lim = pool_limit();
    fresh_left = (lim > int'(fresh_next)) ? lim - int'(fresh_next) : 0;
    return int'(listed_units) + fresh_left;
  endfunction

  // Apply one request to the shadow state and return the grant it yields
  function automatic grant_t predict_grant(logic op, logic [IDX_W-1:0] idx);
    grant_t g;
    int     lim;
    int     product;
    g = '0;
    lim = pool_limit();
    if (op == OP_ALLOC) begin
      if (listed_units > 0) begin
        g.index = list_top;
        list_top = links[list_top];
        listed_units = listed_units - 9'd1;
      end else if (int'(fresh_next) < lim) begin
        g.index = fresh_next[IDX_W-1:0];
        fresh_next = fresh_next + 9'd1;
      end else begin
        g.status = STATUS_EXHAUSTED;
      end
      if (g.status == STATUS_OK) begin
        product = int'(g.index) * rounded_bytes();
        g.offset = product[OFFSET_W-1:0];
      end
    end else begin
      if (int'(idx) >= int'(fresh_next) || int'(idx) >= NUM_UNITS || units_free() >= lim) begin
        g.status = STATUS_REJECTED;
      end else begin
        links[idx] = list_top;
        list_top = idx;
        listed_units = listed_units + 9'd1;
      end
    end
    g.count = COUNT_W'(units_free());
    return g;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      pool_units_q   = POOL_UNITS_RST;
      unit_request_q = UNIT_REQUEST_RST;
      list_top       = '0;
      listed_units   = '0;
      fresh_next     = '0;
      expected_grants.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POOL_UNITS:   pool_units_q   = cfg_data[POOL_W-1:0];
          REG_UNIT_REQUEST: unit_request_q = cfg_data[REQ_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_grants.size() == 0) begin
          fail_count++;
          $display("%0t ns: result beat with none expected, actual status %0d tdata 0x%0h",
                   $time, m_tuser, m_tdata);
        end else begin
          want = expected_grants.pop_front();
          check_field("status", want.status, m_tuser);
          check_field("granted_index", want.index, m_tdata[7:0]);
          check_field("byte_offset", want.offset, m_tdata[25:8]);
          check_field("free_count", want.count, m_tdata[34:26]);
          check_field("pad bits", 0, m_tdata[39:35]);
          checked_count++;
        end
      end
      if (s_tvalid && s_tready)
        expected_grants.push_back(predict_grant(s_tuser, s_tdata[IDX_W-1:0]));
    end
    pending        <= expected_grants.size();
    errors         <= fail_count;
    grants_checked <= checked_count;
  end

endmodule

### tb/sv/fixed_unit_free_list_allocator_unit_test.sv
module fixed_unit_free_list_allocator_unit_test;

  import fla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_UNITS = 256;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;    // [7:0] unit_index
  logic                   s_tuser   = 1'b0;  // [0] op
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  // [7:0] granted_index, [25:8] byte_offset, [34:26] free_count, [39:35] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]    m_tuser;           // [1:0] status
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int errors;
  int pending;
  int grants_checked;

  // When set, neither side idles
  logic calm = 1'b0;

  int beats_sent = 0;
  int settings   = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fixed_unit_free_list_allocator_unit #(
    .NUM_UNITS(NUM_UNITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  fixed_unit_free_list_allocator_checker #(
    .NUM_UNITS(NUM_UNITS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .grants_checked(grants_checked)
  );

  // Receiver: stall at random about 36 percent of the time unless the calm stretch is on
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 36);
  end

  // Offer one request beat and hold it until it is taken. A random gap of
  // idle cycles goes ahead of the beat; valid stays high straight through
  // when no gap is drawn, so it is never dropped and raised in one step.
  task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx);
    while (!calm && $urandom_range(0, 99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= idx;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  // Drop valid and hold off until every expected grant has come back,
  // then let the pipeline settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back; call only while the block is idle
  task automatic set_regs(input int units, input int req);
    cfg_we    <= 1'b1;
    cfg_index <= REG_POOL_UNITS;
    cfg_data  <= CFG_DATA_W'(units);
    @(posedge clk);
    cfg_index <= REG_UNIT_REQUEST;
    cfg_data  <= CFG_DATA_W'(req);
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // One random phase: a given setting, a bias toward allocate or free, and
  // free indexes drawn mostly from a window so frees hit handed-out units.
  // Now and then the sender pauses until everything has come back.
  task automatic random_phase(input int units, input int req, input int n,
                              input int alloc_pct, input int idx_hi);
    logic             op;
    logic [IDX_W-1:0] idx;
    drain();
    set_regs(units, req);
    repeat (n) begin
      op  = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
      idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, idx_hi));
      if ($urandom_range(0, 79) == 0)
        drain();
      send_beat(op, idx);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: free before anything was handed out, with the pool wholly free
    send_beat(OP_FREE, 8'd0);
    // Fresh units come out in ascending order
    send_beat(OP_ALLOC, 8'd0);
    send_beat(OP_ALLOC, 8'hFF);
    send_beat(OP_ALLOC, 8'd0);
    // Double free of the same unit goes undetected; both copies pop back out
    send_beat(OP_FREE, 8'd1);
    send_beat(OP_FREE, 8'd1);
    send_beat(OP_ALLOC, 8'hA5);
    send_beat(OP_ALLOC, 8'h5A);
    // Free of an index that was never handed out
    send_beat(OP_FREE, 8'hFF);
    // LIFO order: last freed comes back first
    send_beat(OP_FREE, 8'd2);
    send_beat(OP_FREE, 8'd0);
    send_beat(OP_ALLOC, 8'd0);
    send_beat(OP_ALLOC, 8'd0);

    // Zero pool: every allocate exhausted, every free rejected
    drain();
    set_regs(0, 0);
    send_beat(OP_ALLOC, 8'd0);
    send_beat(OP_FREE, 8'd0);

    // Pool shrunk below the used range, smallest size rounding
    drain();
    set_regs(1, 1);
    send_beat(OP_ALLOC, 8'd0);
    send_beat(OP_FREE, 8'd1);
    send_beat(OP_ALLOC, 8'd0);
    send_beat(OP_ALLOC, 8'd0);

    // Small pool with room for a few more fresh units, up to exhaustion
    drain();
    set_regs(6, 4);
    repeat (4) send_beat(OP_ALLOC, 8'd0);
    send_beat(OP_FREE, 8'd5);
    send_beat(OP_FREE, 8'd3);

    // Oversize pool register (masks to 511) and the largest request: take
    // every fresh unit so offsets wrap past 18 bits near the top indexes
    drain();
    set_regs(2047, 2047);
    repeat (256) send_beat(OP_ALLOC, IDX_W'($urandom));

    // Calm stretch: no idling on either side
    drain();
    calm <= 1'b1;
    random_phase(256, 8, 180, 50, 255);
    drain();
    calm <= 1'b0;

    random_phase(1, 1, 100, 50, 255);
    random_phase(0, 1024, 30, 50, 255);
    random_phase(255, 1024, 180, 35, 255);
    random_phase(256, 2, 180, 65, 15);
    random_phase(128, 3, 130, 50, 127);
    random_phase(511, 5, 180, 55, 255);
    random_phase($urandom_range(0, 511), $urandom_range(0, 2047), 190, 50, 255);
    random_phase($urandom_range(0, 511), $urandom_range(0, 2047), 190, 45, 255);

    // Wait out every outstanding grant before the summary
    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d request beats and %0d checked grants over %0d register settings,",
             beats_sent, grants_checked, settings);
    $display("including zero, one-unit, shrunk and oversize pools and sizes from 2 to 2048 bytes");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout with %0d grants still expected", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
src/fla_pkg.sv
src/fla_ctrl.sv
src/fla_datapath.sv
src/fixed_unit_free_list_allocator_unit.sv
src/fla_checker.sv
tb/sv/fixed_unit_free_list_allocator_checker.sv
tb/sv/fixed_unit_free_list_allocator_unit_test.sv
